/* hdl/cosine_similarity_top_k_core_defines.svh */
// assertion macros for the cosine similarity top-k core
`ifndef COSINE_SIMILARITY_TOP_K_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_TOP_K_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CSK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("csk check failed");
`define CSK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("csk check failed");
`else
`define CSK_ASSERT(lbl, clk, rst, prop)
`define CSK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hdl/csk_pkg.sv */
// shared constants for the cosine similarity top-k core
package csk_pkg;
  localparam int VOCAB_MAX = 1024;
  localparam int DIM_MAX   = 64;
  localparam int TOP_MAX   = 16;
  localparam int WORD_W    = 10;
  localparam int DIM_W     = 6;
  localparam int ADDR_W    = WORD_W + DIM_W;
  localparam int TOP_W     = 4;
  localparam int CNT_W     = 5;
  localparam int NORM_W    = 38;
  localparam int ROOT_W    = 19;
  localparam logic [1:0] CFG_WORDS = 2'd0;
  localparam logic [1:0] CFG_DIMS  = 2'd1;
  localparam logic [1:0] CFG_READY = 2'd2;
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
endpackage

/* hdl/csk_if.sv */
// valid/ready channel interfaces for input items and results
interface csk_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [9:0]        word_index;
  logic [5:0]        dim_index;
  logic signed [15:0] element_value;
  logic [7:0]        wanted_count;
  modport source(output valid, kind, word_index, dim_index, element_value, wanted_count,
                 input ready);
  modport sink(input valid, kind, word_index, dim_index, element_value, wanted_count,
               output ready);
endinterface

interface csk_out_if;
  logic              valid;
  logic              ready;
  logic [9:0]        found_word;
  logic signed [15:0] similarity;
  logic              has_entry;
  logic              last;
  modport source(output valid, found_word, similarity, has_entry, last, input ready);
  modport sink(input valid, found_word, similarity, has_entry, last, output ready);
endinterface

/* hdl/csk_isqrt.sv */
// iterative floor square root, one result bit per cycle
module csk_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [csk_pkg::NORM_W-1:0]  value,
  output logic                        done,
  output logic [csk_pkg::ROOT_W-1:0]  root
);
  localparam int REM_W = csk_pkg::ROOT_W + 3;
  logic [csk_pkg::NORM_W-1:0] val;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;
  logic [REM_W-1:0] trial;
  logic [4:0] cnt;
  logic busy;

  assign rem_next = {rem[REM_W-3:0], val[csk_pkg::NORM_W-1 -: 2]};
  assign trial = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(csk_pkg::ROOT_W);
        val  <= value;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        val <= {val[csk_pkg::NORM_W-3:0], 2'b00};
        if (rem_next >= trial) begin
          rem  <= rem_next - trial;
          root <= {root[csk_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_next;
          root <= {root[csk_pkg::ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* hdl/cosine_similarity_top_k_core.sv */
// load items: one per cycle into the embedding memory, taken only while no query runs
// query: the query norm first, then per other word a dot product and norm
// (shared multiplier, bit-serial root and divider), a score and a list insert,
// then one result per kept entry; rejected queries emit a single empty result
// rst is synchronous: resets control, counts and config; memory stays as is
`include "cosine_similarity_top_k_core_defines.svh"
module cosine_similarity_top_k_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  csk_in_if.sink      items,
  csk_out_if.source   results
);
  typedef enum logic [4:0] {
    S_IDLE, S_Q_RD, S_Q_MUL, S_Q_ACC, S_Q_SQRT, S_Q_WAIT,
    S_C_NEXT, S_C_RD, S_C_M1, S_C_M2, S_C_A2, S_C_SQRT, S_C_WAIT,
    S_DEN, S_DIVSET, S_DIV, S_INS, S_EMIT, S_EMPTY
  } state_t;

  localparam int DIV_W = 57;
  localparam int Q_W = 18;

  state_t state;
  logic [10:0] words_cfg;
  logic [6:0]  dims_cfg;
  logic        ready_cfg;
  logic [10:0] words;
  logic [6:0]  dims;

  logic signed [15:0] mem [0:csk_pkg::VOCAB_MAX*csk_pkg::DIM_MAX-1];
  logic signed [15:0] rd_a, rd_b;
  logic [csk_pkg::WORD_W-1:0] qword;
  logic [10:0] cand;
  logic [6:0]  d;
  logic [csk_pkg::CNT_W-1:0] keep, keep_calc, best_count, idx;

  logic signed [19:0] mul_a, mul_b;
  logic signed [39:0] mul_p, prod;
  logic signed [37:0] dot;
  logic [csk_pkg::NORM_W-1:0] nacc;
  logic [csk_pkg::ROOT_W-1:0] rq, sq_root;
  logic sq_start, sq_done;
  logic zflag;
  logic [36:0] mag;
  logic [DIV_W-1:0] rem, dsh;
  logic [Q_W-1:0] q;
  logic [4:0] cnt;
  logic signed [15:0] sim_val;

  logic [csk_pkg::WORD_W-1:0] list_word [0:csk_pkg::TOP_MAX-1];
  logic signed [15:0] list_sim [0:csk_pkg::TOP_MAX-1];
  logic [csk_pkg::TOP_MAX-1:0] ge;
  logic accept, q_bad;

  assign words = (words_cfg > 11'(csk_pkg::VOCAB_MAX)) ? 11'(csk_pkg::VOCAB_MAX) : words_cfg;
  assign dims  = (dims_cfg > 7'(csk_pkg::DIM_MAX)) ? 7'(csk_pkg::DIM_MAX) : dims_cfg;
  assign accept = items.valid && items.ready;
  assign items.ready = (state == S_IDLE) && !rst;

  always_comb begin
    keep_calc = (items.wanted_count > 8'(csk_pkg::TOP_MAX)) ?
                csk_pkg::CNT_W'(csk_pkg::TOP_MAX) : csk_pkg::CNT_W'(items.wanted_count);
    if (words != 11'd0 && 11'(keep_calc) > words - 11'd1) begin
      keep_calc = csk_pkg::CNT_W'(words - 11'd1);
    end
    q_bad = !ready_cfg || (11'(items.word_index) >= words) || (keep_calc == '0);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      words_cfg <= '0;
      dims_cfg  <= 7'(csk_pkg::DIM_MAX);
      ready_cfg <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        csk_pkg::CFG_WORDS: words_cfg <= cfg_data;
        csk_pkg::CFG_DIMS:  dims_cfg  <= cfg_data[6:0];
        csk_pkg::CFG_READY: ready_cfg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // embedding memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (accept && items.kind == csk_pkg::KIND_LOAD) begin
      mem[{items.word_index, items.dim_index}] <= items.element_value;
    end
    rd_a <= mem[{qword, d[csk_pkg::DIM_W-1:0]}];
    rd_b <= mem[{cand[csk_pkg::WORD_W-1:0], d[csk_pkg::DIM_W-1:0]}];
  end

  // shared multiplier
  always_comb begin
    mul_a = {{4{rd_a[15]}}, rd_a};
    mul_b = {{4{rd_b[15]}}, rd_b};
    case (state)
      S_Q_MUL: mul_b = {{4{rd_a[15]}}, rd_a};
      S_C_M2:  mul_a = {{4{rd_b[15]}}, rd_b};
      S_DEN: begin
        mul_a = {1'b0, rq};
        mul_b = {1'b0, sq_root};
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sq_start = (state == S_Q_SQRT) || (state == S_C_SQRT);

  csk_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(nacc), .done(sq_done), .root(sq_root)
  );

  assign mag = dot[37] ? 37'(-dot) : 37'(dot);

  always_comb begin
    if (zflag) sim_val = '0;
    else if (dot[37]) sim_val = (q >= Q_W'(32768)) ? 16'sh8000 : 16'(-q);
    else sim_val = (q > Q_W'(32767)) ? 16'sh7fff : 16'(q);
  end

  // entries at or above the new score stay ahead of it
  always_comb begin
    for (int i = 0; i < csk_pkg::TOP_MAX; i++) begin
      ge[i] = (csk_pkg::CNT_W'(i) < best_count) && (list_sim[i] >= sim_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      best_count <= '0;
      results.valid <= 1'b0;
    end else begin
      // the emit states reload or hold the output register themselves
      if (results.valid && results.ready && state != S_EMIT && state != S_EMPTY) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && items.kind == csk_pkg::KIND_QUERY) begin
            qword      <= items.word_index;
            keep       <= keep_calc;
            best_count <= '0;
            d          <= '0;
            nacc       <= '0;
            if (q_bad) state <= S_EMPTY;
            else if (dims == 7'd0) state <= S_Q_SQRT;
            else state <= S_Q_RD;
          end
        end
        S_Q_RD:  state <= S_Q_MUL;
        S_Q_MUL: begin
          prod  <= mul_p;
          state <= S_Q_ACC;
        end
        S_Q_ACC: begin
          nacc <= nacc + csk_pkg::NORM_W'(prod[37:0]);
          d    <= d + 7'd1;
          state <= (d + 7'd1 == dims) ? S_Q_SQRT : S_Q_RD;
        end
        S_Q_SQRT: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (sq_done) begin
            rq    <= sq_root;
            cand  <= '0;
            state <= S_C_NEXT;
          end
        end
        S_C_NEXT: begin
          if (cand == words) begin
            idx   <= '0;
            state <= S_EMIT;
          end else if (cand[csk_pkg::WORD_W-1:0] == qword) begin
            cand <= cand + 11'd1;
          end else begin
            dot  <= '0;
            nacc <= '0;
            d    <= '0;
            state <= (dims == 7'd0) ? S_C_SQRT : S_C_RD;
          end
        end
        S_C_RD: state <= S_C_M1;
        S_C_M1: begin
          prod  <= mul_p;
          state <= S_C_M2;
        end
        S_C_M2: begin
          dot   <= dot + prod[37:0];
          prod  <= mul_p;
          state <= S_C_A2;
        end
        S_C_A2: begin
          nacc <= nacc + csk_pkg::NORM_W'(prod[37:0]);
          d    <= d + 7'd1;
          state <= (d + 7'd1 == dims) ? S_C_SQRT : S_C_RD;
        end
        S_C_SQRT: state <= S_C_WAIT;
        S_C_WAIT: if (sq_done) state <= S_DEN;
        S_DEN: begin
          prod  <= mul_p;
          zflag <= (rq == '0) || (sq_root == '0);
          state <= S_DIVSET;
        end
        S_DIVSET: begin
          // numerator |dot|*65536 + den over divisor 2*den
          rem   <= DIV_W'({mag, 16'd0}) + DIV_W'(prod[37:0]);
          dsh   <= DIV_W'({prod[37:0], 1'b0}) << (Q_W - 1);
          q     <= '0;
          cnt   <= 5'(Q_W);
          state <= zflag ? S_INS : S_DIV;
        end
        S_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            q   <= {q[Q_W-2:0], 1'b1};
          end else begin
            q <= {q[Q_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) state <= S_INS;
        end
        S_INS: begin
          if (!ge[keep[csk_pkg::TOP_W-1:0] - csk_pkg::TOP_W'(1)] || keep > best_count) begin
            for (int i = 0; i < csk_pkg::TOP_MAX; i++) begin
              if (!ge[i]) begin
                if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                  list_word[i] <= cand[csk_pkg::WORD_W-1:0];
                  list_sim[i]  <= sim_val;
                end else begin
                  list_word[i] <= list_word[(i == 0) ? 0 : i - 1];
                  list_sim[i]  <= list_sim[(i == 0) ? 0 : i - 1];
                end
              end
            end
            if (best_count < keep) best_count <= best_count + csk_pkg::CNT_W'(1);
          end
          cand  <= cand + 11'd1;
          state <= S_C_NEXT;
        end
        S_EMIT: begin
          if (!results.valid || results.ready) begin
            results.valid      <= 1'b1;
            results.found_word <= list_word[idx[csk_pkg::TOP_W-1:0]];
            results.similarity <= list_sim[idx[csk_pkg::TOP_W-1:0]];
            results.has_entry  <= 1'b1;
            results.last       <= (idx + csk_pkg::CNT_W'(1) == best_count);
            idx <= idx + csk_pkg::CNT_W'(1);
            if (idx + csk_pkg::CNT_W'(1) == best_count) state <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (!results.valid || results.ready) begin
            results.valid      <= 1'b1;
            results.found_word <= '0;
            results.similarity <= '0;
            results.has_entry  <= 1'b0;
            results.last       <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSK_ASSERT(a_count_le_keep, clk, rst, (state != S_IDLE) |-> (best_count <= keep))
  `CSK_ASSERT(a_empty_is_last, clk, rst, (results.valid && !results.has_entry) |-> results.last)
  `CSK_ASSERT(a_query_blocks, clk, rst, (accept && items.kind == csk_pkg::KIND_QUERY) |=> !items.ready)
endmodule
